@@ src/stratified_poisson_sample_acceptor_assert.svh @@
// Assertion macros used by the acceptor RTL.
`ifndef STRATIFIED_POISSON_SAMPLE_ACCEPTOR_ASSERT_SVH
`define STRATIFIED_POISSON_SAMPLE_ACCEPTOR_ASSERT_SVH
`ifndef SYNTHESIS
`define SPSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SPSA_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPSA_ASSERT(lbl, prop, msg)
`define SPSA_ASSERT_NR(lbl, prop, msg)
`endif
`endif

@@ src/spsa_pkg.sv @@
`timescale 1ns / 1ps
package spsa_pkg;

  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_OCCUPIED = 3'd1;
  localparam logic [2:0] ST_CLOSE    = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_CLEARED  = 3'd4;

  localparam logic [2:0] MODE_RANDOM  = 3'd0;
  localparam logic [2:0] MODE_JITTER  = 3'd1;
  localparam logic [2:0] MODE_POISSON = 3'd2;
  localparam logic [2:0] MODE_PJITTER = 3'd3;
  localparam logic [2:0] MODE_HIER    = 3'd4;

  localparam logic [1:0] REG_MODE      = 2'd0;
  localparam logic [1:0] REG_RADIUS    = 2'd1;
  localparam logic [1:0] REG_PJ_RADIUS = 2'd2;

  localparam logic       CMD_CLEAR = 1'b0;

  typedef struct packed {
    logic        command;
    logic [15:0] cand_x;
    logic [15:0] cand_y;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  sample_index;
    logic [15:0] sample_x;
    logic [15:0] sample_y;
    logic        sequence_done;
  } out_beat_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

@@ src/stratified_poisson_sample_acceptor.sv @@
`timescale 1ns / 1ps
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid/in_ready   | in_data (command, cand_x, cand_y)
// out     | output    | out_valid/out_ready | out_data (status, index, x, y, done)
// cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
// A clear, a full rejection or a grid test registers its result for the finish state.
// A Poisson test rotates the point chain once through the distance unit.
// Its result is registered once the distance unit drains, for the finish state.
// Reset empties the chain and the occupancy maps at once and restores the config registers.
// One item is in work at a time; a result held on out keeps the next item in its final step.
`include "stratified_poisson_sample_acceptor_assert.svh"
module stratified_poisson_sample_acceptor #(
  parameter int SEQUENCE_LENGTH = 256,
  parameter int COORD_BITS      = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  spsa_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output spsa_pkg::out_beat_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  localparam int N    = SEQUENCE_LENGTH;
  localparam int CW   = COORD_BITS;
  localparam int CNTW = $clog2(N + 1);
  localparam int SCW  = $clog2(N + 4);
  localparam int LSH  = (CW >= 16) ? CW - 16 : 0;
  localparam int RSH  = (CW < 16) ? 16 - CW : 0;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_t;

  state_t          state;
  logic [2:0]      mode;
  logic [15:0]     poisson_radius, poisson_jitter_radius;
  logic [CW-1:0]   cx, cy;
  logic [CNTW-1:0] count;
  logic [3:0]      occ1;
  logic [15:0]     occ2;
  logic [63:0]     occ3;
  logic [255:0]    occ4;
  logic [2:0]      res_status;
  logic [2*CW-1:0] r2;
  logic [SCW-1:0]  scan_cnt;
  logic            close_acc;

  logic [CW+15:0]  ext_x, ext_y, rw, ox, oy;
  logic [CW-1:0]   in_x, in_y, r_sc;
  logic [15:0]     r_sel;
  logic [7:0]      i1, i2, i3, i4, k1, k2, k3, k4;
  logic            accept, rotating, fire, commit, hit;
  logic            grid_occ, needs_scan;
  spsa_pkg::cell_ctrl_t ctrl;

  logic              cv [N];
  logic [CW-1:0]     cxs [N];
  logic [CW-1:0]     cys [N];

  function automatic logic [7:0] cell_idx(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                          input int k);
    logic [CW-1:0] a, b;
    a = x >> (CW - k);
    b = y >> (CW - k);
    return 8'(a + (b << k));
  endfunction

  assign ext_x = {CW'(0), in_data.cand_x};
  assign ext_y = {CW'(0), in_data.cand_y};
  assign in_x  = ext_x[CW-1:0];
  assign in_y  = ext_y[CW-1:0];
  assign ox    = {16'(0), cx};
  assign oy    = {16'(0), cy};

  assign r_sel = (mode == spsa_pkg::MODE_PJITTER) ? poisson_jitter_radius : poisson_radius;
  assign rw    = {CW'(0), r_sel};
  assign r_sc  = CW'((rw << LSH) >> RSH);

  assign i1 = cell_idx(in_x, in_y, 1);
  assign i2 = cell_idx(in_x, in_y, 2);
  assign i3 = cell_idx(in_x, in_y, 3);
  assign i4 = cell_idx(in_x, in_y, 4);
  assign k1 = cell_idx(cx, cy, 1);
  assign k2 = cell_idx(cx, cy, 2);
  assign k3 = cell_idx(cx, cy, 3);
  assign k4 = cell_idx(cx, cy, 4);

  always_comb begin
    grid_occ   = 1'b0;
    needs_scan = 1'b0;
    case (mode)
      spsa_pkg::MODE_JITTER: begin
        grid_occ = occ4[i4];
      end
      spsa_pkg::MODE_POISSON: begin
        needs_scan = 1'b1;
      end
      spsa_pkg::MODE_PJITTER: begin
        grid_occ   = occ4[i4];
        needs_scan = !occ4[i4];
      end
      spsa_pkg::MODE_HIER: begin
        if (32'(count) < 32'd4) begin
          grid_occ = occ1[i1[1:0]];
        end else if (32'(count) < 32'd16) begin
          grid_occ = occ2[i2[3:0]];
        end else if (32'(count) < 32'd64) begin
          grid_occ = occ3[i3[5:0]];
        end else begin
          grid_occ = occ4[i4];
        end
      end
      default: ;
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign rotating  = (state == S_SCAN) && (scan_cnt < SCW'(N));
  assign fire      = (state == S_FINISH) && (!out_valid || out_ready);
  assign commit    = fire && (res_status == spsa_pkg::ST_ACCEPTED);
  assign ctrl.shift = rotating || commit;
  assign ctrl.clear = accept && (in_data.command == spsa_pkg::CMD_CLEAR);

  for (genvar g = 0; g < N; g++) begin : g_chain
    if (g == 0) begin : g_head
      spsa_cell #(.COORD_BITS(CW)) u_cell (
        .clk(clk), .rst(rst), .ctrl(ctrl),
        .valid_in(commit ? 1'b1 : cv[N-1]),
        .x_in(commit ? cx : cxs[N-1]),
        .y_in(commit ? cy : cys[N-1]),
        .valid_out(cv[0]), .x_out(cxs[0]), .y_out(cys[0])
      );
    end else begin : g_body
      spsa_cell #(.COORD_BITS(CW)) u_cell (
        .clk(clk), .rst(rst), .ctrl(ctrl),
        .valid_in(cv[g-1]), .x_in(cxs[g-1]), .y_in(cys[g-1]),
        .valid_out(cv[g]), .x_out(cxs[g]), .y_out(cys[g])
      );
    end
  end

  spsa_dist #(.COORD_BITS(CW)) u_dist (
    .clk(clk), .rst(rst),
    .feed(rotating && cv[N-1]),
    .px(cxs[N-1]), .py(cys[N-1]),
    .cx(cx), .cy(cy), .r2(r2),
    .hit(hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state                 <= S_IDLE;
      mode                  <= spsa_pkg::MODE_RANDOM;
      poisson_radius        <= 16'd2949;
      poisson_jitter_radius <= 16'd1835;
      count                 <= '0;
      occ1                  <= '0;
      occ2                  <= '0;
      occ3                  <= '0;
      occ4                  <= '0;
      out_valid             <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          spsa_pkg::REG_MODE:      mode <= cfg_data[2:0];
          spsa_pkg::REG_RADIUS:    poisson_radius <= cfg_data;
          spsa_pkg::REG_PJ_RADIUS: poisson_jitter_radius <= cfg_data;
          default: ;
        endcase
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            cx        <= in_x;
            cy        <= in_y;
            r2        <= r_sc * r_sc;
            scan_cnt  <= '0;
            close_acc <= 1'b0;
            if (in_data.command == spsa_pkg::CMD_CLEAR) begin
              count      <= '0;
              occ1       <= '0;
              occ2       <= '0;
              occ3       <= '0;
              occ4       <= '0;
              res_status <= spsa_pkg::ST_CLEARED;
              state      <= S_FINISH;
            end else if (count == CNTW'(N)) begin
              res_status <= spsa_pkg::ST_FULL;
              state      <= S_FINISH;
            end else begin
              res_status <= grid_occ ? spsa_pkg::ST_OCCUPIED : spsa_pkg::ST_ACCEPTED;
              state      <= needs_scan ? S_SCAN : S_FINISH;
            end
          end
        end
        S_SCAN: begin
          scan_cnt  <= scan_cnt + SCW'(1);
          close_acc <= close_acc | hit;
          if (scan_cnt == SCW'(N + 3)) begin
            res_status <= close_acc ? spsa_pkg::ST_CLOSE : spsa_pkg::ST_ACCEPTED;
            state      <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (fire) begin
            out_data.status        <= res_status;
            out_data.sample_index  <= commit ? 8'(count) : 8'd0;
            out_data.sample_x      <= commit ? ox[15:0] : 16'd0;
            out_data.sample_y      <= commit ? oy[15:0] : 16'd0;
            out_data.sequence_done <= commit && ((count + CNTW'(1)) == CNTW'(N));
            if (commit) begin
              count         <= count + CNTW'(1);
              occ1[k1[1:0]] <= 1'b1;
              occ2[k2[3:0]] <= 1'b1;
              occ3[k3[5:0]] <= 1'b1;
              occ4[k4]      <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SPSA_ASSERT(a_count_bound, count <= CNTW'(N), "sample count beyond sequence length")
  `SPSA_ASSERT(a_commit_inc, commit |=> count == $past(count) + CNTW'(1), "count missed a commit")
  `SPSA_ASSERT(a_clear_empties, ctrl.clear |=> count == '0 && !cv[0], "clear left samples")

endmodule

@@ src/spsa_cell.sv @@
`timescale 1ns / 1ps
module spsa_cell #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  spsa_pkg::cell_ctrl_t  ctrl,
  input  logic                  valid_in,
  input  logic [COORD_BITS-1:0] x_in,
  input  logic [COORD_BITS-1:0] y_in,
  output logic                  valid_out,
  output logic [COORD_BITS-1:0] x_out,
  output logic [COORD_BITS-1:0] y_out
);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      valid_out <= 1'b0;
    end else if (ctrl.shift) begin
      valid_out <= valid_in;
    end
    if (ctrl.shift) begin
      x_out <= x_in;
      y_out <= y_in;
    end
  end

endmodule

@@ src/spsa_dist.sv @@
`timescale 1ns / 1ps
module spsa_dist #(
  parameter int COORD_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    feed,
  input  logic [COORD_BITS-1:0]   px,
  input  logic [COORD_BITS-1:0]   py,
  input  logic [COORD_BITS-1:0]   cx,
  input  logic [COORD_BITS-1:0]   cy,
  input  logic [2*COORD_BITS-1:0] r2,
  output logic                    hit
);

  localparam int CW = COORD_BITS;
  localparam logic [CW-1:0] HALF = CW'(1) << (CW - 1);

  logic [CW-1:0]   adx, ady, wdx, wdy;
  logic [CW-1:0]   dx, dy;
  logic [2*CW-1:0] dx2, dy2;
  logic            v1, v2;

  always_comb begin
    adx = (px > cx) ? px - cx : cx - px;
    ady = (py > cy) ? py - cy : cy - py;
    wdx = (adx > HALF) ? CW'(0) - adx : adx;
    wdy = (ady > HALF) ? CW'(0) - ady : ady;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      hit <= 1'b0;
    end else begin
      v1  <= feed;
      v2  <= v1;
      hit <= v2 && ((dx2 + dy2) < r2);
    end
    dx  <= wdx;
    dy  <= wdy;
    dx2 <= dx * dx;
    dy2 <= dy * dy;
  end

endmodule
